FILE: rtl/core/bsc_pkg.sv
// shared types, constants and helpers for the barometric compensation block
package bsc_pkg;

  localparam int unsigned RawW = 20;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_TEMP_CAL = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LOW = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LAST = 8'd3;

  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] RawFull = 64'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;

  typedef enum logic {
    KIND_TEMP = 1'b0,
    KIND_PRESS = 1'b1
  } bsc_kind_e;

  typedef struct packed {
    bsc_kind_e kind;
    logic [RawW-1:0] raw;
  } bsc_item_t;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_last;
  } bsc_cal_t;

  function automatic logic [63:0] sx16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
    return $signed(x) >>> s;
  endfunction

endpackage

FILE: rtl/core/bsc_if.sv
// channel interfaces: sample input, result output and register write
interface bsc_sample_if;
  import bsc_pkg::*;
  logic valid;
  logic ready;
  logic operation;
  logic [RawW-1:0] raw_sample;
  modport source (output valid, output operation, output raw_sample, input ready);
  modport sink (input valid, input operation, input raw_sample, output ready);
endinterface

interface bsc_result_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic signed [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic pressure_zero_divisor;
  modport source (output valid, output result_kind, output temperature_centi,
                  output pressure_q24_8, output pressure_zero_divisor, input ready);
  modport sink (input valid, input result_kind, input temperature_centi,
                input pressure_q24_8, input pressure_zero_divisor, output ready);
endinterface

interface bsc_cfg_if;
  import bsc_pkg::*;
  logic valid;
  logic ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/barometric_sensor_compensation.sv
// top level of the barometric compensation block: registers, front and back end
// How long a temperature or pressure transaction takes from the back end picking it
// up is set by the one shared 32x32 multiplier (three partial products per 64-bit
// product, up to ten products for pressure) and the radix-2 divider; a two-entry
// queue in front takes samples meanwhile. Pressure uses the fine temperature of the
// last temperature transaction, zero after reset; register writes are taken at any
// time and belong to idle periods.
module barometric_sensor_compensation import bsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsc_sample_if.sink   sample_i,
  bsc_result_if.source result_o,
  bsc_cfg_if.sink      cfg_i
);

  bsc_cal_t  cal_q;
  logic      item_valid, item_ready;
  bsc_item_t item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TEMP_CAL: cal_q.temp_cal <= cfg_i.data[47:0];
        REG_PRESS_LOW: cal_q.press_low <= cfg_i.data;
        REG_PRESS_HIGH: cal_q.press_high <= cfg_i.data;
        REG_PRESS_LAST: cal_q.press_last <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk_i, .rst_ni, .sample_i,
    .item_valid_o(item_valid), .item_ready_i(item_ready), .item_o(item)
  );

  bsc_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(item_valid), .item_ready_o(item_ready), .item_i(item),
    .cal_i(cal_q), .result_o
  );

endmodule

FILE: rtl/core/bsc_front.sv
// front end: accepts samples, classifies them and queues them for the back end
module bsc_front import bsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  bsc_sample_if.sink        sample_i,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output bsc_item_t         item_o
);

  bsc_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign sample_i.ready = (count_q != 2'd2);
  assign push = sample_i.valid && sample_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign pop = item_valid_o && item_ready_i;
  assign item_o = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) count_d = count_q + 2'd1;
    else if (pop && !push) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q].kind <= sample_i.operation ? KIND_PRESS : KIND_TEMP;
      mem_q[wptr_q].raw <= sample_i.raw_sample;
    end
  end

endmodule

FILE: rtl/core/bsc_mul.sv
// 64x64 multiplier keeping the low 64 bits, three 32x32 partial products in turn
module bsc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q, b_q, acc_q, pp_q;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] mx, my;

  always_comb begin
    case (cnt_q)
      2'd0: begin mx = a_q[31:0];  my = b_q[31:0];  end
      2'd1: begin mx = a_q[31:0];  my = b_q[63:32]; end
      2'd2: begin mx = a_q[63:32]; my = b_q[31:0];  end
      default: begin mx = '0; my = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      pp_q <= mx * my;
      case (cnt_q)
        2'd1: acc_q <= pp_q;
        2'd2, 2'd3: acc_q <= acc_q + {pp_q[31:0], 32'd0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o = acc_q;

endmodule

FILE: rtl/core/bsc_div.sv
// signed 64-bit radix-2 divider truncating toward zero, divisor nonzero
module bsc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  input  logic [63:0] d_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  logic [63:0] rem_q, quo_q, ad_q;
  logic        neg_q, busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [64:0] sh, diff;
  logic        fits;

  assign sh = {rem_q, quo_q[63]};
  assign diff = sh - {1'b0, ad_q};
  assign fits = !diff[64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= n_i[63] ^ d_i[63];
      quo_q <= n_i[63] ? (64'd0 - n_i) : n_i;
      ad_q <= d_i[63] ? (64'd0 - d_i) : d_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[63:0] : sh[63:0];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  assign done_o = done_q;
  assign q_o = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

FILE: rtl/core/bsc_back.sv
// back end: sequences the compensation formulas over the shared multiplier and the divider
module bsc_back import bsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  bsc_item_t  item_i,
  input  bsc_cal_t   cal_i,
  bsc_result_if.source result_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0 = 5'd1;
  localparam logic [4:0] S_T1 = 5'd2;
  localparam logic [4:0] S_T2 = 5'd3;
  localparam logic [4:0] S_P0 = 5'd4;
  localparam logic [4:0] S_P1 = 5'd5;
  localparam logic [4:0] S_P2 = 5'd6;
  localparam logic [4:0] S_P3 = 5'd7;
  localparam logic [4:0] S_P4 = 5'd8;
  localparam logic [4:0] S_P5 = 5'd9;
  localparam logic [4:0] S_P6 = 5'd10;
  localparam logic [4:0] S_P7 = 5'd11;
  localparam logic [4:0] S_P8 = 5'd12;
  localparam logic [4:0] S_P9 = 5'd13;
  localparam logic [4:0] S_P10 = 5'd14;
  localparam logic [4:0] S_FIN = 5'd15;
  localparam logic [4:0] S_OUT = 5'd16;

  logic [4:0]      step_q;
  logic            issued_q;
  logic [RawW-1:0] raw_q;
  bsc_kind_e       kind_q;
  logic [31:0]     fine_q, fine_d;
  logic [63:0]     v1_q, v2_q, sq_q, q_q, tmp_q;
  logic [31:0]     res_temp_q;
  logic [31:0]     res_press_q;
  logic            res_zero_q;
  logic            out_valid_q, out_kind_q, out_zero_q;
  logic [31:0]     out_temp_q, out_press_q;

  logic [15:0] t1;
  logic [63:0] t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] ta, tb;
  logic [63:0] pr, qs, v1_new;
  logic        is_mul, mul_start, mul_busy, mul_done, div_start, div_done;
  logic [63:0] ma, mb, mul_p, div_q;

  assign t1 = cal_i.temp_cal[15:0];
  assign t2 = sx16(cal_i.temp_cal[31:16]);
  assign t3 = sx16(cal_i.temp_cal[47:32]);
  assign p1 = {48'd0, cal_i.press_low[15:0]};
  assign p2 = sx16(cal_i.press_low[31:16]);
  assign p3 = sx16(cal_i.press_low[47:32]);
  assign p4 = sx16(cal_i.press_low[63:48]);
  assign p5 = sx16(cal_i.press_high[15:0]);
  assign p6 = sx16(cal_i.press_high[31:16]);
  assign p7 = sx16(cal_i.press_high[47:32]);
  assign p8 = sx16(cal_i.press_high[63:48]);
  assign p9 = sx16(cal_i.press_last);

  assign ta = 32'(raw_q >> 3) - {15'd0, t1, 1'b0};
  assign tb = 32'(raw_q >> 4) - {16'd0, t1};
  assign pr = RawFull - 64'(raw_q);
  assign qs = asr64(q_q, 6'd13);

  always_comb begin
    case (step_q)
      S_T0:  begin ma = 64'(ta); mb = t2; end
      S_T1:  begin ma = 64'(tb); mb = 64'(tb); end
      S_T2:  begin ma = tmp_q; mb = t3; end
      S_P0:  begin ma = v1_q; mb = v1_q; end
      S_P1:  begin ma = sq_q; mb = p6; end
      S_P2:  begin ma = v1_q; mb = p5; end
      S_P3:  begin ma = sq_q; mb = p3; end
      S_P4:  begin ma = v1_q; mb = p2; end
      S_P5:  begin ma = (64'd1 << 47) + v1_q; mb = p1; end
      S_P6:  begin ma = (pr << 31) - v2_q; mb = PressScale; end
      S_P8:  begin ma = p9; mb = qs; end
      S_P9:  begin ma = tmp_q; mb = qs; end
      S_P10: begin ma = p8; mb = q_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign is_mul = (step_q inside {[S_T0:S_P6], [S_P8:S_P10]});
  assign mul_start = is_mul && !issued_q;
  assign div_start = (step_q == S_P7) && !issued_q;
  assign item_ready_o = (step_q == S_IDLE);

  assign fine_d = v1_q[31:0] + asr32(mul_p[31:0], 5'd14);
  assign v1_new = asr64(mul_p, 6'd33);

  bsc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb),
    .busy_o(mul_busy), .done_o(mul_done), .p_o(mul_p)
  );

  bsc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(tmp_q), .d_i(v1_q),
    .done_o(div_done), .q_o(div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
      issued_q <= 1'b0;
      fine_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_start || div_start) issued_q <= 1'b1;
      if (step_q == S_OUT && (!out_valid_q || result_o.ready)) out_valid_q <= 1'b1;
      else if (out_valid_q && result_o.ready) out_valid_q <= 1'b0;
      case (step_q)
        S_IDLE: begin
          if (item_valid_i) begin
            step_q <= (item_i.kind == KIND_PRESS) ? S_P0 : S_T0;
          end
        end
        S_T2: begin
          if (mul_done) begin
            fine_q <= fine_d;
            step_q <= S_OUT;
            issued_q <= 1'b0;
          end
        end
        S_P5: begin
          if (mul_done) begin
            step_q <= (v1_new == 64'd0) ? S_OUT : S_P6;
            issued_q <= 1'b0;
          end
        end
        S_P7: begin
          if (div_done) begin
            step_q <= S_P8;
            issued_q <= 1'b0;
          end
        end
        S_P10: begin
          if (mul_done) begin
            step_q <= S_FIN;
            issued_q <= 1'b0;
          end
        end
        S_FIN: step_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_q || result_o.ready) begin
            step_q <= S_IDLE;
          end
        end
        default: begin
          if (mul_done) begin
            step_q <= step_q + 5'd1;
            issued_q <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (step_q)
      S_IDLE: begin
        if (item_valid_i) begin
          raw_q <= item_i.raw;
          kind_q <= item_i.kind;
          v1_q <= sx16(16'd0) + {{32{fine_q[31]}}, fine_q} - FineOffset;
          res_temp_q <= '0;
          res_press_q <= '0;
          res_zero_q <= 1'b0;
        end
      end
      S_T0: if (mul_done) v1_q <= 64'(asr32(mul_p[31:0], 5'd11));
      S_T1: if (mul_done) tmp_q <= 64'(asr32(mul_p[31:0], 5'd12));
      S_T2: if (mul_done) res_temp_q <= asr32((fine_d << 2) + fine_d + 32'd128, 5'd8);
      S_P0: if (mul_done) sq_q <= mul_p;
      S_P1: if (mul_done) v2_q <= mul_p;
      S_P2: if (mul_done) v2_q <= v2_q + (mul_p << 17) + (p4 << 35);
      S_P3: if (mul_done) tmp_q <= asr64(mul_p, 6'd8);
      S_P4: if (mul_done) v1_q <= tmp_q + (mul_p << 12);
      S_P5: begin
        if (mul_done) begin
          v1_q <= v1_new;
          res_zero_q <= (v1_new == 64'd0);
        end
      end
      S_P6: if (mul_done) tmp_q <= mul_p;
      S_P7: if (div_done) q_q <= div_q;
      S_P8: if (mul_done) tmp_q <= mul_p;
      S_P9: if (mul_done) v1_q <= asr64(mul_p, 6'd25);
      S_P10: if (mul_done) tmp_q <= q_q + v1_q + asr64(mul_p, 6'd19);
      S_FIN: res_press_q <= 32'(asr64(tmp_q, 6'd8) + (p7 << 4));
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_kind_q <= (kind_q == KIND_PRESS);
          out_temp_q <= res_temp_q;
          out_press_q <= res_press_q;
          out_zero_q <= res_zero_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid = out_valid_q;
  assign result_o.result_kind = out_kind_q;
  assign result_o.temperature_centi = out_temp_q;
  assign result_o.pressure_q24_8 = out_press_q;
  assign result_o.pressure_zero_divisor = out_zero_q;

`ifndef NO_ASSERTIONS
  a_mul_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");
  a_div_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (step_q == S_P7)) else $error("divider finished outside its step");
  a_temp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_kind_q) |-> (out_press_q == 32'd0 && !out_zero_q))
    else $error("temperature result carries pressure fields");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_ready_o) |=> (step_q != S_IDLE))
    else $error("item taken without starting work");
`endif

endmodule

FILE: test/tb_top.sv
// testbench for the barometric compensation block: scoreboard, stimulus and checks
module tb_top;
  import bsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [31:0] temp;
    logic [31:0] press;
    logic        zero;
  } comp_result_t;

  class comp_scoreboard;
    logic [47:0] temp_cal;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_last;
    logic [31:0] fine_temp;
    comp_result_t pending[$];
    int errors;

    function new();
      temp_cal = '0;
      press_low = '0;
      press_high = '0;
      press_last = '0;
      fine_temp = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [63:0] val);
      case (idx)
        REG_TEMP_CAL:   temp_cal = val[47:0];
        REG_PRESS_LOW:  press_low = val;
        REG_PRESS_HIGH: press_high = val;
        REG_PRESS_LAST: press_last = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic op, logic [19:0] raw);
      comp_result_t r;
      logic [31:0] t1, t2, t3, a, b, v1, v2;
      logic signed [63:0] ft, w1, w2, p, q, s1, s2, p1;
      r.kind = op;
      r.temp = '0;
      r.press = '0;
      r.zero = 1'b0;
      if (op == KIND_TEMP) begin
        t1 = {16'd0, temp_cal[15:0]};
        t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
        t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
        a = {15'd0, raw[19:3]} - (t1 << 1);
        v1 = $signed(a * t2) >>> 11;
        b = {16'd0, raw[19:4]} - t1;
        v2 = $signed(32'($signed(b * b) >>> 12) * t3) >>> 14;
        fine_temp = v1 + v2;
        r.temp = $signed(fine_temp * 32'd5 + 32'd128) >>> 8;
      end else begin
        ft = {{32{fine_temp[31]}}, fine_temp};
        w1 = ft - 64'sd128000;
        w2 = w1 * w1 * $signed({{48{press_high[31]}}, press_high[31:16]});
        w2 = w2 + ((w1 * $signed({{48{press_high[15]}}, press_high[15:0]})) << 17);
        w2 = w2 + ($signed({{48{press_low[63]}}, press_low[63:48]}) << 35);
        w1 = ((w1 * w1 * $signed({{48{press_low[47]}}, press_low[47:32]})) >>> 8)
             + ((w1 * $signed({{48{press_low[31]}}, press_low[31:16]})) << 12);
        p1 = {48'd0, press_low[15:0]};
        w1 = ((64'sd1 <<< 47) + w1) * p1 >>> 33;
        if (w1 == 0) begin
          r.zero = 1'b1;
        end else begin
          p = 64'sd1048576 - $signed({44'd0, raw});
          q = ((p << 31) - w2) * 64'sd3125;
          if (q == 64'sh8000000000000000 && w1 == -64'sd1) p = q;
          else p = q / w1;
          s1 = ($signed({{48{press_last[15]}}, press_last}) * (p >>> 13) * (p >>> 13))
               >>> 25;
          s2 = ($signed({{48{press_high[63]}}, press_high[63:48]}) * p) >>> 19;
          p = ((p + s1 + s2) >>> 8)
              + ($signed({{48{press_high[47]}}, press_high[47:32]}) << 4);
          r.press = p[31:0];
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(comp_result_t got);
      comp_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("result_kind expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.temp !== e.temp) begin
        $error("temperature_centi expected %0d actual %0d",
               $signed(e.temp), $signed(got.temp)); errors++;
      end
      if (got.press !== e.press) begin
        $error("pressure_q24_8 expected %h actual %h", e.press, got.press); errors++;
      end
      if (got.zero !== e.zero) begin
        $error("pressure_zero_divisor expected %0d actual %0d", e.zero, got.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  bsc_sample_if sample_bus();
  bsc_result_if result_bus();
  bsc_cfg_if    cfg_bus();

  barometric_sensor_compensation uut (
    .clk_i(clk), .rst_ni(rst_n),
    .sample_i(sample_bus.sink), .result_o(result_bus.source), .cfg_i(cfg_bus.sink)
  );

  comp_scoreboard sb;
  bit calm, hold_long;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sample_bus.valid = 0; sample_bus.operation = 0; sample_bus.raw_sample = '0;
    cfg_bus.valid = 0; cfg_bus.index = '0; cfg_bus.data = '0;
    result_bus.ready = 0;
  end

  task automatic write_reg(logic [7:0] idx, logic [63:0] val);
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    cfg_bus.valid <= 1;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, val);
    cfg_bus.valid <= 0;
  endtask

  task automatic send_sample(logic op, logic [19:0] raw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      sample_bus.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    sample_bus.operation <= op;
    sample_bus.raw_sample <= raw;
    sample_bus.valid <= 1;
    do @(posedge clk); while (!sample_bus.ready);
    sb.note_sample(op, raw);
  endtask

  task automatic drain;
    sample_bus.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_cal(int mode);
    write_reg(REG_TEMP_CAL, mode == 0 ? 64'd0 : mode == 1 ? {$urandom, $urandom}
              : {16'h0000, 16'd6700, 16'd26500, 16'd27500});
    write_reg(REG_PRESS_LOW, mode == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : mode == 1 ?
              {$urandom, $urandom} : {16'd9000, 16'hFFF9, 16'hD5D0, 16'd36500});
    write_reg(REG_PRESS_HIGH, mode == 0 ? 64'h8000_7FFF_8000_7FFF : mode == 1 ?
              {$urandom, $urandom} : {16'hFFF1, 16'd15500, 16'hFFF9, 16'd140});
    write_reg(REG_PRESS_LAST, mode == 0 ? 64'hFFFF_FFFF_FFFF_8000 : mode == 1 ?
              {$urandom, $urandom} : 64'd6000);
    write_reg(8'd4 + 8'($urandom_range(0, 250)), {$urandom, $urandom});
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        result_bus.ready <= 0;
        repeat (2000) @(posedge clk);
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        result_bus.ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      result_bus.ready <= 1;
    end
  end

  always @(posedge clk) begin
    comp_result_t got;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      got.kind = result_bus.result_kind;
      got.temp = result_bus.temperature_centi;
      got.press = result_bus.pressure_q24_8;
      got.zero = result_bus.pressure_zero_divisor;
      sb.check_result(got);
    end
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // pressure before any temperature, zero divisor with reset calibration
    send_sample(KIND_PRESS, 20'd0);
    send_sample(KIND_TEMP, 20'hFFFFF);
    drain();
    random_cal(2);
    send_sample(KIND_PRESS, 20'd415148);
    send_sample(KIND_TEMP, 20'd519888);
    send_sample(KIND_PRESS, 20'd415148);
    send_sample(KIND_PRESS, 20'hFFFFF);
    send_sample(KIND_PRESS, 20'd0);
    send_sample(KIND_TEMP, 20'd0);
    send_sample(KIND_PRESS, 20'h80000);
    drain();
    random_cal(0);
    send_sample(KIND_TEMP, 20'hFFFFF);
    send_sample(KIND_PRESS, 20'hFFFFF);
    send_sample(KIND_TEMP, 20'd0);
    send_sample(KIND_PRESS, 20'd0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      random_cal(ph % 3 == 0 ? 1 : 2);
      if (ph == 1) hold_long = 1;
      if (ph == 5) calm = 1;
      for (int i = 0; i < 80; i++)
        send_sample($urandom_range(0, 2) != 0, 20'($urandom));
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
